/* rtl/core/gear_shift_jam_recovery_fsm_core_assert.svh */
// Assertion macros for the gear shift sequencer core.
// Used by gear_shift_jam_recovery_fsm_core.sv; no other dependencies.
`ifndef GEAR_SHIFT_JAM_RECOVERY_FSM_CORE_ASSERT_SVH
`define GEAR_SHIFT_JAM_RECOVERY_FSM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// ante holds in a cycle: cons must hold in the same cycle
`define GSJR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// ante holds in a cycle: cons must hold in the next cycle
`define GSJR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GSJR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define GSJR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/core/gsjr_pkg.sv */
// Types, constants and helper functions for the gear shift sequencer core.
// No dependencies.
package gsjr_pkg;

   localparam int unsigned MAX_GEAR = 4;
   localparam int unsigned GEAR_W   = 8;
   localparam int unsigned TICK_W   = 24;
   localparam int unsigned MASK_W   = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   // Register reset values
   localparam logic [TICK_W-1:0]  BRAKE_TICKS_RST  = 24'd3000;
   localparam logic [TICK_W-1:0]  UNJAM_TICKS_RST  = 24'd1000;
   localparam logic signed [7:0]  BRAKE_VALUE_RST  = -8'sd100;
   localparam logic signed [7:0]  IDLE_VALUE_RST   = 8'sd0;
   localparam logic signed [7:0]  UNJAM_VALUE_RST  = 8'sd25;
   localparam logic [7:0]         RETRY_LIMIT_RST  = 8'd2;
   localparam logic               BRAKE_ENABLE_RST = 1'b1;
   localparam logic [MASK_W-1:0]  REVERT_MASK_RST  = 5'd26;
   localparam logic [GEAR_W-1:0]  GEAR_INVALID     = 8'd255;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_CHECK    = 3'd1,
      MODE_BRAKE    = 3'd2,
      MODE_SHIFT    = 3'd3,
      MODE_REVERT   = 3'd4,
      MODE_THROTTLE = 3'd5,
      MODE_CANCEL   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      OP_SHIFT_REQ  = 3'd0,
      OP_JAM        = 3'd1,
      OP_GEAR_PASS  = 3'd2,
      OP_CANCEL     = 3'd3,
      OP_INPUT_SEL  = 3'd4,
      OP_UI_SEL     = 3'd5,
      OP_TICK       = 3'd6
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRAKE_TICKS  = 3'd0,
      CSR_UNJAM_TICKS  = 3'd1,
      CSR_BRAKE_VALUE  = 3'd2,
      CSR_IDLE_VALUE   = 3'd3,
      CSR_UNJAM_VALUE  = 3'd4,
      CSR_RETRY_LIMIT  = 3'd5,
      CSR_BRAKE_ENABLE = 3'd6,
      CSR_REVERT_MASK  = 3'd7
   } csr_idx_type;

   // Working copy of the sequencer state and result flags for one event
   typedef struct packed {
      mode_type           mode;
      logic [GEAR_W-1:0]  target;
      logic [GEAR_W-1:0]  revert;
      logic [TICK_W-1:0]  countdown;
      logic               gear_v;
      logic [3:0]         gear;
      logic               thr_v;
      logic signed [7:0]  thr;
      logic               cancel;
      logic               passreq;
   } work_type;

   function automatic logic gear_ok(input logic [GEAR_W-1:0] g);
      return g <= GEAR_W'(MAX_GEAR);
   endfunction

   // A zero tick count acts as one
   function automatic logic [TICK_W-1:0] load_ticks(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   // Nearest revertable gear from 'from', upward or downward; invalid if none
   function automatic logic [GEAR_W-1:0] find_revert(input logic [GEAR_W-1:0] from,
                                                     input logic up,
                                                     input logic [MASK_W-1:0] mask);
      logic [GEAR_W-1:0] res;
      res = GEAR_INVALID;
      if (up) begin
         for (int g = MASK_W - 1; g >= 0; g--) begin
            if (g <= MAX_GEAR && mask[g] && GEAR_W'(g) >= from) res = GEAR_W'(g);
         end
      end else begin
         for (int g = 0; g < MASK_W; g++) begin
            if (g <= MAX_GEAR && mask[g] && GEAR_W'(g) <= from) res = GEAR_W'(g);
         end
      end
      return res;
   endfunction

endpackage

/* rtl/core/gear_shift_jam_recovery_fsm_core.sv */
// Gear shift sequencer with jam recovery: event in, one result per event.
// Depends on gsjr_pkg and gear_shift_jam_recovery_fsm_core_assert.svh.
//
// One event is taken per clock while rsp_tready holds, and every event gives exactly one result.
// An event passes an input register, then the whole state transition,
// including chained mode changes and the revert gear search, is resolved
// combinationally into the result register, which loads when the event
// leaves the input register; that step waits while a held result is not
// taken on rsp_tready, and the sustained rate is one event per cycle.
// The result register and the input register together let a new event in
// while a finished result waits on rsp_tready. Configuration writes are always
// accepted and take effect on the next event.
module gear_shift_jam_recovery_fsm_core (
   input  logic                               clock,
   input  logic                               reset,
   // events
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gsjr_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] gear_value, [8] select_flag
   input  logic [2:0]                         req_tuser,  // [2:0] opcode
   // results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gsjr_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [2:0] mode, [3] gear_cmd_valid,
                                                          // [7:4] gear_cmd, [8] throttle_valid,
                                                          // [16:9] throttle_cmd,
                                                          // [17] cancel_out,
                                                          // [18] pass_gear_request
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gsjr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gsjr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gsjr_pkg::*;

   // configuration registers
   logic [TICK_W-1:0]  brake_ticks_ff;
   logic [TICK_W-1:0]  unjam_ticks_ff;
   logic signed [7:0]  brake_value_ff;
   logic signed [7:0]  idle_value_ff;
   logic signed [7:0]  unjam_value_ff;
   logic [7:0]         retry_limit_ff;
   logic               brake_enable_ff;
   logic [MASK_W-1:0]  revert_mask_ff;

   // sequencer state
   mode_type           mode_ff, mode_in;
   logic [GEAR_W-1:0]  requested_ff, requested_in;
   logic [GEAR_W-1:0]  target_ff, target_in;
   logic [GEAR_W-1:0]  last_rep_ff, last_rep_in;
   logic [GEAR_W-1:0]  passed_ff, passed_in;
   logic [GEAR_W-1:0]  revert_ff, revert_in;
   logic [7:0]         attempt_ff, attempt_in;
   logic [TICK_W-1:0]  countdown_ff, countdown_in;
   logic               input_sel_ff, input_sel_in;
   logic               ui_sel_ff, ui_sel_in;

   // input stage
   logic               stage_valid_ff;
   logic [2:0]         stage_op_ff;
   logic [GEAR_W-1:0]  stage_gear_ff;
   logic               stage_sel_ff;

   // result stage
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic advance;

   // Run the chain of mode entries that one entry can trigger
   function automatic work_type enter_chain(input work_type w_i,
                                            input mode_type start,
                                            input logic [GEAR_W-1:0] requested,
                                            input logic [GEAR_W-1:0] last_rep,
                                            input logic [GEAR_W-1:0] passed,
                                            input logic brake_en,
                                            input logic [TICK_W-1:0] brake_ticks,
                                            input logic signed [7:0] brake_value,
                                            input logic [MASK_W-1:0] mask);
      work_type w;
      mode_type st;
      logic     go;
      w  = w_i;
      st = start;
      go = 1'b1;
      // longest chain is check, brake, shift
      for (int i = 0; i < 4; i++) begin
         if (go) begin
            go = 1'b0;
            if (!gear_ok(passed)) w.passreq = 1'b1;
            w.mode = st;
            unique case (st)
               MODE_CHECK: begin
                  if (!gear_ok(requested) || !gear_ok(last_rep) || requested == last_rep) begin
                     st = MODE_CANCEL;
                  end else begin
                     w.target = requested;
                     st = MODE_BRAKE;
                  end
                  go = 1'b1;
               end
               MODE_BRAKE: begin
                  if (brake_en) begin
                     w.thr_v     = 1'b1;
                     w.thr       = brake_value;
                     w.countdown = load_ticks(brake_ticks);
                  end else begin
                     st = MODE_SHIFT;
                     go = 1'b1;
                  end
               end
               MODE_SHIFT: begin
                  if (!gear_ok(w.target)) begin
                     st = MODE_IDLE;
                     go = 1'b1;
                  end else begin
                     w.gear_v = 1'b1;
                     w.gear   = w.target[3:0];
                  end
               end
               MODE_REVERT: begin
                  if (!gear_ok(passed) || !gear_ok(w.target)) begin
                     st = MODE_CANCEL;
                     go = 1'b1;
                  end else begin
                     w.revert = find_revert(w.target, passed > w.target, mask);
                     if (!gear_ok(w.revert)) begin
                        st = MODE_IDLE;
                        go = 1'b1;
                     end else begin
                        w.gear_v = 1'b1;
                        w.gear   = w.revert[3:0];
                     end
                  end
               end
               MODE_CANCEL: w.cancel = 1'b1;
               default: ;
            endcase
         end
      end
      return w;
   endfunction

   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brake_ticks_ff  <= BRAKE_TICKS_RST;
         unjam_ticks_ff  <= UNJAM_TICKS_RST;
         brake_value_ff  <= BRAKE_VALUE_RST;
         idle_value_ff   <= IDLE_VALUE_RST;
         unjam_value_ff  <= UNJAM_VALUE_RST;
         retry_limit_ff  <= RETRY_LIMIT_RST;
         brake_enable_ff <= BRAKE_ENABLE_RST;
         revert_mask_ff  <= REVERT_MASK_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BRAKE_TICKS:  brake_ticks_ff  <= csr_data[TICK_W-1:0];
            CSR_UNJAM_TICKS:  unjam_ticks_ff  <= csr_data[TICK_W-1:0];
            CSR_BRAKE_VALUE:  brake_value_ff  <= csr_data[7:0];
            CSR_IDLE_VALUE:   idle_value_ff   <= csr_data[7:0];
            CSR_UNJAM_VALUE:  unjam_value_ff  <= csr_data[7:0];
            CSR_RETRY_LIMIT:  retry_limit_ff  <= csr_data[7:0];
            CSR_BRAKE_ENABLE: brake_enable_ff <= csr_data[0];
            CSR_REVERT_MASK:  revert_mask_ff  <= csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture an event on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         stage_op_ff   <= req_tuser;
         stage_gear_ff <= req_tdata[7:0];
         stage_sel_ff  <= req_tdata[8];
      end
   end

   // Resolve one event: next state and result
   always_comb begin
      work_type w;
      logic     go_throttle;
      w            = '0;
      w.mode       = mode_ff;
      w.target     = target_ff;
      w.revert     = revert_ff;
      w.countdown  = countdown_ff;
      go_throttle  = 1'b0;
      requested_in = requested_ff;
      last_rep_in  = last_rep_ff;
      passed_in    = passed_ff;
      attempt_in   = attempt_ff;
      input_sel_in = input_sel_ff;
      ui_sel_in    = ui_sel_ff;

      unique case (op_type'(stage_op_ff))
         OP_SHIFT_REQ: begin
            requested_in = stage_gear_ff;
            attempt_in   = '0;
            if (input_sel_ff && ui_sel_ff) begin
               w = enter_chain(w, MODE_CHECK, stage_gear_ff, last_rep_ff, passed_ff,
                               brake_enable_ff, brake_ticks_ff, brake_value_ff,
                               revert_mask_ff);
            end
         end
         OP_JAM: begin
            if (w.mode == MODE_SHIFT) begin
               w = enter_chain(w, MODE_REVERT, requested_ff, last_rep_ff, passed_ff,
                               brake_enable_ff, brake_ticks_ff, brake_value_ff,
                               revert_mask_ff);
            end
            if (w.mode == MODE_REVERT) begin
               go_throttle = attempt_ff < retry_limit_ff;
               attempt_in  = attempt_ff + 8'd1;
               if (go_throttle) begin
                  w = enter_chain(w, MODE_THROTTLE, requested_ff, last_rep_ff, passed_ff,
                                  brake_enable_ff, brake_ticks_ff, brake_value_ff,
                                  revert_mask_ff);
               end
            end
            if (w.mode == MODE_THROTTLE) begin
               w.thr_v     = 1'b1;
               w.thr       = unjam_value_ff;
               w.countdown = load_ticks(unjam_ticks_ff);
            end
         end
         OP_GEAR_PASS: begin
            last_rep_in = stage_gear_ff;
            if (w.mode == MODE_SHIFT && w.target == stage_gear_ff) begin
               w = enter_chain(w, MODE_IDLE, requested_ff, stage_gear_ff, passed_ff,
                               brake_enable_ff, brake_ticks_ff, brake_value_ff,
                               revert_mask_ff);
               w.thr_v = 1'b1;
               w.thr   = idle_value_ff;
            end
            if (w.mode == MODE_REVERT && w.revert == stage_gear_ff) begin
               w = enter_chain(w, MODE_CHECK, requested_ff, stage_gear_ff, passed_ff,
                               brake_enable_ff, brake_ticks_ff, brake_value_ff,
                               revert_mask_ff);
            end
            passed_in = stage_gear_ff;
         end
         OP_CANCEL: begin
            w = enter_chain(w, MODE_IDLE, requested_ff, last_rep_ff, passed_ff,
                            brake_enable_ff, brake_ticks_ff, brake_value_ff,
                            revert_mask_ff);
         end
         OP_INPUT_SEL: input_sel_in = stage_sel_ff;
         OP_UI_SEL:    ui_sel_in    = stage_sel_ff;
         OP_TICK: begin
            if (countdown_ff != '0) begin
               w.countdown = countdown_ff - TICK_W'(1);
               if (w.countdown == '0) begin
                  if (w.mode == MODE_BRAKE) begin
                     w = enter_chain(w, MODE_SHIFT, requested_ff, last_rep_ff, passed_ff,
                                     brake_enable_ff, brake_ticks_ff, brake_value_ff,
                                     revert_mask_ff);
                  end else if (w.mode == MODE_THROTTLE) begin
                     w = enter_chain(w, MODE_CHECK, requested_ff, last_rep_ff, passed_ff,
                                     brake_enable_ff, brake_ticks_ff, brake_value_ff,
                                     revert_mask_ff);
                  end
               end
            end
         end
         default: ;
      endcase

      mode_in      = w.mode;
      target_in    = w.target;
      revert_in    = w.revert;
      countdown_in = w.countdown;
      rsp_data_in  = {5'd0, w.passreq, w.cancel, w.thr, w.thr_v, w.gear, w.gear_v,
                      w.mode};
   end

   // Advance sequencer state on each processed event
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         requested_ff <= '0;
         target_ff    <= '0;
         last_rep_ff  <= GEAR_INVALID;
         passed_ff    <= GEAR_INVALID;
         revert_ff    <= GEAR_INVALID;
         attempt_ff   <= '0;
         countdown_ff <= '0;
         input_sel_ff <= 1'b0;
         ui_sel_ff    <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         requested_ff <= requested_in;
         target_ff    <= target_in;
         last_rep_ff  <= last_rep_in;
         passed_ff    <= passed_in;
         revert_ff    <= revert_in;
         attempt_ff   <= attempt_in;
         countdown_ff <= countdown_in;
         input_sel_ff <= input_sel_in;
         ui_sel_ff    <= ui_sel_in;
      end
   end

   // Hold the result until its transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`include "gear_shift_jam_recovery_fsm_core_assert.svh"

   // a cancel announcement always leaves the sequencer in cancel
   `GSJR_ASSERT_IMPLY(a_cancel_mode, clock, reset, rsp_valid_ff && rsp_data_ff[17],
      rsp_data_ff[2:0] == MODE_CANCEL, "cancel_out without cancel mode")
   // a commanded gear is always a valid gear
   `GSJR_ASSERT_IMPLY(a_gear_range, clock, reset, rsp_valid_ff && rsp_data_ff[3],
      rsp_data_ff[7:4] <= 4'(MAX_GEAR), "gear command out of range")
   // a stalled event stays in the input stage
   `GSJR_ASSERT_NEXT(a_stage_hold, clock, reset, stage_valid_ff && !advance,
      stage_valid_ff && $stable(stage_op_ff), "input stage lost an event")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the gear shift sequencer with jam recovery.
// Drives events, predicts every result from a behavioral copy of the sequencer
// and compares it field by field. Depends on gsjr_pkg and the core RTL.
module tb;
   import gsjr_pkg::*;

   // opcode outside the defined set, must leave the state untouched
   localparam logic [2:0] OP_UNKNOWN = 3'd7;

   // result fields, mode in the lowest bits
   typedef struct packed {
      logic       passreq;
      logic       cancel;
      logic [7:0] thr;
      logic       thr_v;
      logic [3:0] gear;
      logic       gear_v;
      logic [2:0] mode;
   } shift_result_type;

   // Behavioral sequencer plus the queue of results it still owes
   class gear_shift_predictor_type;
      logic [23:0]      brake_ticks, unjam_ticks;
      logic [7:0]       brake_value, idle_value, unjam_value, retry_limit;
      logic             brake_en;
      logic [4:0]       revert_mask;
      mode_type         cur_mode;
      logic [7:0]       requested, target, last_seen, passed, revert_to, attempts;
      logic [23:0]      countdown;
      logic             in_sel, ui_sel;
      shift_result_type step_out;
      shift_result_type pending_results[$];
      int               mismatches;

      function new();
         brake_ticks = BRAKE_TICKS_RST;
         unjam_ticks = UNJAM_TICKS_RST;
         brake_value = BRAKE_VALUE_RST;
         idle_value  = IDLE_VALUE_RST;
         unjam_value = UNJAM_VALUE_RST;
         retry_limit = RETRY_LIMIT_RST;
         brake_en    = BRAKE_ENABLE_RST;
         revert_mask = REVERT_MASK_RST;
         cur_mode    = MODE_IDLE;
         requested   = '0;
         target      = '0;
         last_seen   = GEAR_INVALID;
         passed      = GEAR_INVALID;
         revert_to   = GEAR_INVALID;
         attempts    = '0;
         countdown   = '0;
         in_sel      = 1'b0;
         ui_sel      = 1'b0;
         mismatches  = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [23:0] d);
         unique case (idx)
            CSR_BRAKE_TICKS:  brake_ticks = d;
            CSR_UNJAM_TICKS:  unjam_ticks = d;
            CSR_BRAKE_VALUE:  brake_value = d[7:0];
            CSR_IDLE_VALUE:   idle_value  = d[7:0];
            CSR_UNJAM_VALUE:  unjam_value = d[7:0];
            CSR_RETRY_LIMIT:  retry_limit = d[7:0];
            CSR_BRAKE_ENABLE: brake_en    = d[0];
            CSR_REVERT_MASK:  revert_mask = d[4:0];
            default: ;
         endcase
      endfunction

      // a programmed count of zero still runs for one tick
      function logic [23:0] loaded_count(logic [23:0] v);
         return (v == '0) ? 24'd1 : v;
      endfunction

      // walk from the jammed target toward the passed gear side
      function logic [7:0] nearest_revert(logic [7:0] from, bit up);
         int g;
         g = from;
         while (g >= 0 && g <= MAX_GEAR) begin
            if (revert_mask[g]) return 8'(g);
            g = up ? g + 1 : g - 1;
         end
         return GEAR_INVALID;
      endfunction

      // follow chained mode changes until one settles
      function void enter_mode(mode_type first);
         mode_type st;
         bit       more;
         st   = first;
         more = 1'b1;
         while (more) begin
            more = 1'b0;
            if (passed > MAX_GEAR) step_out.passreq = 1'b1;
            cur_mode = st;
            unique case (st)
               MODE_CHECK: begin
                  more = 1'b1;
                  if (requested > MAX_GEAR || last_seen > MAX_GEAR || requested == last_seen)
                     st = MODE_CANCEL;
                  else begin
                     target = requested;
                     st     = MODE_BRAKE;
                  end
               end
               MODE_BRAKE: begin
                  if (brake_en) begin
                     step_out.thr_v = 1'b1;
                     step_out.thr   = brake_value;
                     countdown      = loaded_count(brake_ticks);
                  end else begin
                     st   = MODE_SHIFT;
                     more = 1'b1;
                  end
               end
               MODE_SHIFT: begin
                  if (target > MAX_GEAR) begin
                     st   = MODE_IDLE;
                     more = 1'b1;
                  end else begin
                     step_out.gear_v = 1'b1;
                     step_out.gear   = target[3:0];
                  end
               end
               MODE_REVERT: begin
                  if (passed > MAX_GEAR || target > MAX_GEAR) begin
                     st   = MODE_CANCEL;
                     more = 1'b1;
                  end else begin
                     revert_to = nearest_revert(target, passed > target);
                     if (revert_to > MAX_GEAR) begin
                        st   = MODE_IDLE;
                        more = 1'b1;
                     end else begin
                        step_out.gear_v = 1'b1;
                        step_out.gear   = revert_to[3:0];
                     end
                  end
               end
               MODE_CANCEL: step_out.cancel = 1'b1;
               default: ;
            endcase
         end
      endfunction

      // apply one accepted event and queue the result it owes
      function void note_event(logic [2:0] op, logic [7:0] g, logic sel);
         bit go;
         step_out = '0;
         unique case (op)
            OP_SHIFT_REQ: begin
               requested = g;
               attempts  = '0;
               if (in_sel && ui_sel) enter_mode(MODE_CHECK);
            end
            OP_JAM: begin
               if (cur_mode == MODE_SHIFT) enter_mode(MODE_REVERT);
               if (cur_mode == MODE_REVERT) begin
                  go       = attempts < retry_limit;
                  attempts = attempts + 8'd1;
                  if (go) enter_mode(MODE_THROTTLE);
               end
               if (cur_mode == MODE_THROTTLE) begin
                  step_out.thr_v = 1'b1;
                  step_out.thr   = unjam_value;
                  countdown      = loaded_count(unjam_ticks);
               end
            end
            OP_GEAR_PASS: begin
               last_seen = g;
               if (cur_mode == MODE_SHIFT && target == g) begin
                  enter_mode(MODE_IDLE);
                  step_out.thr_v = 1'b1;
                  step_out.thr   = idle_value;
               end
               if (cur_mode == MODE_REVERT && revert_to == g) enter_mode(MODE_CHECK);
               passed = g;
            end
            OP_CANCEL:    enter_mode(MODE_IDLE);
            OP_INPUT_SEL: in_sel = sel;
            OP_UI_SEL:    ui_sel = sel;
            OP_TICK: begin
               if (countdown != '0) begin
                  countdown = countdown - 24'd1;
                  if (countdown == '0) begin
                     if (cur_mode == MODE_BRAKE) enter_mode(MODE_SHIFT);
                     else if (cur_mode == MODE_THROTTLE) enter_mode(MODE_CHECK);
                  end
               end
            end
            default: ;
         endcase
         step_out.mode = cur_mode;
         pending_results.push_back(step_out);
      endfunction

      function int field_diff(string name, int want, int got);
         if (want == got) return 0;
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      endfunction

      // compare one delivered result with the oldest owed one
      function void check_result(logic [23:0] data);
         shift_result_type got, want;
         got = data[18:0];
         if (pending_results.size() == 0) begin
            $error("result 0x%h arrived with no event outstanding", data);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         mismatches += field_diff("mode", want.mode, got.mode);
         mismatches += field_diff("gear_cmd_valid", want.gear_v, got.gear_v);
         mismatches += field_diff("gear_cmd", want.gear, got.gear);
         mismatches += field_diff("throttle_valid", want.thr_v, got.thr_v);
         mismatches += field_diff("throttle_cmd", int'($signed(want.thr)),
                                  int'($signed(got.thr)));
         mismatches += field_diff("cancel_out", want.cancel, got.cancel);
         mismatches += field_diff("pass_gear_request", want.passreq, got.passreq);
      endfunction
   endclass

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata   = '0;
   logic [2:0]               req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index   = '0;
   logic [CSR_DATA_W-1:0]    csr_data    = '0;

   int                       send_gap_pct = 0;
   int                       recv_gap_pct = 0;
   logic                     hold_rsp     = 1'b0;
   logic                     squeeze_req  = 1'b0;
   gear_shift_predictor_type book;

   gear_shift_jam_recovery_fsm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Accept results and randomly stall the result side
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Hold off the result side for a long stretch once asked
   initial begin : result_squeeze
      do @(posedge clock); while (!squeeze_req);
      hold_rsp <= 1'b1;
      repeat (60) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic set_idling(int send_pct, int recv_pct);
      send_gap_pct <= send_pct;
      recv_gap_pct <= recv_pct;
   endtask

   // one event transfer, after a random gap
   task automatic send_event(logic [2:0] op, logic [7:0] g, logic sel);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, sel, g};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_event(op, g, sel);
   endtask

   // drop valid and wait until every owed result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.pending_results.size() != 0);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [23:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_reg(idx, d);
   endtask

   // program every register; only called while the block is idle
   task automatic apply_settings(int bt, int ut, int bv, int iv, int uv, int rl, int be,
                                 int rm);
      csr_write(CSR_BRAKE_TICKS, 24'(bt));
      csr_write(CSR_UNJAM_TICKS, 24'(ut));
      csr_write(CSR_BRAKE_VALUE, {16'd0, 8'(bv)});
      csr_write(CSR_IDLE_VALUE, {16'd0, 8'(iv)});
      csr_write(CSR_UNJAM_VALUE, {16'd0, 8'(uv)});
      csr_write(CSR_RETRY_LIMIT, 24'(rl));
      csr_write(CSR_BRAKE_ENABLE, 24'(be));
      csr_write(CSR_REVERT_MASK, 24'(rm));
      csr_valid <= 1'b0;
   endtask

   task automatic apply_random_settings();
      apply_settings($urandom_range(6, 1), $urandom_range(6, 1),
                     int'($urandom_range(200)) - 100, int'($urandom_range(200)) - 100,
                     int'($urandom_range(200)) - 100, $urandom_range(3),
                     $urandom_range(1), $urandom_range(31));
   endtask

   // Mostly events that move the current mode forward, some noise
   task automatic pick_event(output logic [2:0] op, output logic [7:0] g, output logic sel);
      int r;
      r   = $urandom_range(99);
      sel = 1'b1;
      g   = 8'($urandom_range(MAX_GEAR));
      op  = OP_TICK;
      if (r < 10) begin
         op  = 3'($urandom_range(7));
         g   = 8'($urandom);
         sel = 1'($urandom);
      end else if (!(book.in_sel && book.ui_sel)) begin
         op = book.in_sel ? OP_UI_SEL : OP_INPUT_SEL;
      end else begin
         unique case (book.cur_mode)
            MODE_BRAKE, MODE_THROTTLE: begin
               if (r < 80) op = OP_TICK;
               else if (r < 92) op = OP_JAM;
               else op = OP_CANCEL;
            end
            MODE_SHIFT: begin
               if (r < 55) begin
                  op = OP_GEAR_PASS;
                  g  = book.target;
               end else if (r < 92) op = OP_JAM;
               else op = OP_GEAR_PASS;
            end
            MODE_REVERT: begin
               if (r < 50) op = OP_JAM;
               else if (r < 85) begin
                  op = OP_GEAR_PASS;
                  g  = book.revert_to;
               end else if (r < 93) op = OP_TICK;
               else op = OP_CANCEL;
            end
            default: begin
               if (r < 60) begin
                  op = OP_SHIFT_REQ;
                  if (g == book.last_seen) g = 8'((g + 1) % (MAX_GEAR + 1));
               end else if (r < 85) op = OP_GEAR_PASS;
               else if (r < 92) op = OP_JAM;
               else op = OP_TICK;
            end
         endcase
      end
   endtask

   task automatic run_random(int count, bit squeeze, bit pause_mid);
      logic [2:0] op;
      logic [7:0] g;
      logic       sel;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) wait_drained();
         if (squeeze && i == 4) squeeze_req <= 1'b1;
         pick_event(op, g, sel);
         send_event(op, g, sel);
      end
   endtask

   initial begin : stimulus
      book = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk: short timers, zero unjam count acts as one
      set_idling(30, 60);
      apply_settings(2, 0, -100, 0, 25, 2, 1, 26);
      send_event(OP_UNKNOWN, 8'd0, 1'b0);
      send_event(OP_SHIFT_REQ, 8'd2, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_JAM, 8'd0, 1'b0);
      send_event(OP_INPUT_SEL, 8'd0, 1'b1);
      send_event(OP_UI_SEL, 8'd0, 1'b1);
      send_event(OP_SHIFT_REQ, 8'd2, 1'b0);
      send_event(OP_GEAR_PASS, 8'd1, 1'b0);
      send_event(OP_SHIFT_REQ, 8'd255, 1'b0);
      send_event(OP_SHIFT_REQ, 8'd1, 1'b0);
      send_event(OP_SHIFT_REQ, 8'd3, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_JAM, 8'd0, 1'b0);
      send_event(OP_JAM, 8'd0, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_TICK, 8'd0, 1'b0);
      send_event(OP_GEAR_PASS, 8'd3, 1'b0);
      send_event(OP_SHIFT_REQ, 8'd0, 1'b0);
      send_event(OP_CANCEL, 8'd0, 1'b0);
      send_event(OP_GEAR_PASS, 8'd255, 1'b0);
      send_event(OP_INPUT_SEL, 8'd0, 1'b0);
      wait_drained();

      // Extremes: no retries, every gear revertable
      apply_settings(3, 2, 100, -100, -100, 0, 1, 31);
      run_random(90, 1'b0, 1'b0);
      wait_drained();

      // Brake skipped, retry limit of 255, no revertable gear
      set_idling(60, 30);
      apply_settings(1, 1, 100, 100, 100, 255, 0, 0);
      run_random(80, 1'b0, 1'b0);
      wait_drained();

      // Longest timers: brake never expires here
      apply_settings(16777215, 16777215, -100, 0, 25, 1, 1, 1);
      run_random(30, 1'b0, 1'b0);
      wait_drained();

      // Back to back, long result stall and a full drain midway
      set_idling(0, 0);
      apply_random_settings();
      run_random(120, 1'b1, 1'b1);
      wait_drained();

      apply_random_settings();
      run_random(110, 1'b0, 1'b0);
      wait_drained();

      repeat (8) @(posedge clock);
      if (book.mismatches == 0 && book.pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
